FILE: rtl/dls_pkg.sv
package dls_pkg;

   typedef enum logic [2:0] {
      MODE_OOS    = 3'd0,
      MODE_UNIDX  = 3'd1,
      MODE_IDLE   = 3'd2,
      MODE_RUN    = 3'd3,
      MODE_UNSAFE = 3'd4,
      MODE_BRAKE  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_CRC  = 2'd1,
      STATUS_LOST = 2'd2
   } status_type;

   localparam logic [1:0] UPD_CLEAR = 2'd1;
   localparam logic [1:0] UPD_SET   = 2'd2;

   localparam logic CSR_ERROR_LIMIT   = 1'b0;
   localparam logic CSR_PING_INTERVAL = 1'b1;

   localparam logic [7:0]  ERROR_LIMIT_RESET   = 8'd3;
   localparam logic [31:0] PING_INTERVAL_RESET = 32'd1000;
   localparam logic [7:0]  ERROR_COUNT_MAX     = 8'd255;

   typedef struct packed {
      logic [31:0] now_time;
      logic        synch_ok;
      logic        write_error;
      logic        read_crc_error;
      logic        start_event;
      logic        stop_event;
      logic        ping_reply;
      logic [1:0]  index_update;
      logic [1:0]  safe_update;
      logic [1:0]  motor_update;
   } req_type;

   typedef struct packed {
      logic [2:0] mode_code;
      logic [1:0] pass_status;
      logic       ping_request;
      logic       index_query;
      logic       just_synched;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  error_limit;
      logic [31:0] ping_interval;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic        synced;
      logic        start_pending;
      logic        stop_pending;
      logic        indexed;
      logic        safe_level;
      logic        motor_is_off;
      logic [7:0]  link_errors;
      logic [31:0] ping_stamp;
      logic        ping_answered;
   } sup_state_type;

   localparam sup_state_type SUP_STATE_RESET = '{
      mode:          MODE_OOS,
      synced:        1'b0,
      start_pending: 1'b0,
      stop_pending:  1'b0,
      indexed:       1'b0,
      safe_level:    1'b1,
      motor_is_off:  1'b1,
      link_errors:   8'd0,
      ping_stamp:    32'd0,
      ping_answered: 1'b1
   };

   function automatic logic apply_update(input logic level, input logic [1:0] code);
      logic result;
      result = level;
      if (code == UPD_CLEAR) begin
         result = 1'b0;
      end else if (code == UPD_SET) begin
         result = 1'b1;
      end
      return result;
   endfunction

endpackage

FILE: rtl/driver_link_supervisor_fsm_core.sv
// Driver link supervisor. Each request beat is one pass of the supervisor
// loop: a timestamp, the link results of the pass and the received events.
// Each request beat yields exactly one response beat with the mode after
// the pass, the pass status and the ping, index query and sync pulses.
// A request beat is taken when req_valid is high and req_stall is low; a
// response beat is delivered when rsp_valid is high and rsp_stall is low.
// The request is registered, the pass is evaluated against the supervisor
// state, and the result lands in the response register, which drives
// rsp_valid. One beat per cycle is sustained while rsp_stall is low: the
// state register takes the update of each pass and the next pass reads it at
// once. When rsp_stall holds a result, the input register still takes one
// more beat, after which req_stall is raised until the response is taken.
// The csr channel is always ready; index 0 writes the error limit and
// index 1 the ping interval. Reset is synchronous and returns the state
// to out of sync with the limit at 3 and the interval at 1000 time units.
module driver_link_supervisor_fsm_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dls_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dls_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [31:0]      csr_data
);
   import dls_pkg::*;

   cfg_type       cfg_ff;
   sup_state_type state_ff;
   sup_state_type state_in;
   req_type       beat_ff;
   logic          beat_valid_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_valid_ff;
   logic          out_free;
   logic          advance;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = beat_valid_ff && out_free;
   assign req_stall = beat_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   dls_pass u_pass (
      .cfg       (cfg_ff),
      .cur_state (state_ff),
      .beat      (beat_ff),
      .nxt_state (state_in),
      .result    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.error_limit   <= ERROR_LIMIT_RESET;
         cfg_ff.ping_interval <= PING_INTERVAL_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ERROR_LIMIT) begin
            cfg_ff.error_limit <= csr_data[7:0];
         end else begin
            cfg_ff.ping_interval <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SUP_STATE_RESET;
         beat_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (req_valid && !req_stall) begin
            beat_valid_ff <= 1'b1;
         end else if (advance) begin
            beat_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         beat_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: rtl/dls_pass.sv
module dls_pass (
   input  dls_pkg::cfg_type       cfg,
   input  dls_pkg::sup_state_type cur_state,
   input  dls_pkg::req_type       beat,
   output dls_pkg::sup_state_type nxt_state,
   output dls_pkg::rsp_type       result
);
   import dls_pkg::*;

   sup_state_type st;
   mode_type      mode_nxt;
   status_type    status;
   logic [8:0]    err_sum;
   logic [31:0]   age;
   logic          ping_due;
   logic          lost;
   logic          ping_req;
   logic          idx_q;
   logic          just;

   assign age      = beat.now_time - cur_state.ping_stamp;
   assign ping_due = (cur_state.mode != MODE_OOS) && (age >= cfg.ping_interval);

   always_comb begin
      st      = cur_state;
      status  = STATUS_OK;
      err_sum = {1'b0, cur_state.link_errors};
      if (cur_state.synced) begin
         err_sum = {1'b0, cur_state.link_errors} + 9'(beat.write_error)
                   + 9'(beat.read_crc_error);
         if (err_sum > {1'b0, ERROR_COUNT_MAX}) begin
            st.link_errors = ERROR_COUNT_MAX;
         end else begin
            st.link_errors = err_sum[7:0];
         end
         if (beat.read_crc_error) begin
            status = STATUS_CRC;
         end else begin
            if (beat.start_event) begin
               st.start_pending = 1'b1;
            end
            if (beat.stop_event) begin
               st.stop_pending = 1'b1;
            end
            if (beat.ping_reply) begin
               st.ping_answered = 1'b1;
            end
            st.indexed      = apply_update(cur_state.indexed, beat.index_update);
            st.safe_level   = apply_update(cur_state.safe_level, beat.safe_update);
            st.motor_is_off = apply_update(cur_state.motor_is_off, beat.motor_update);
         end
      end
   end

   assign lost = (st.link_errors >= cfg.error_limit) || (ping_due && !st.ping_answered);

   always_comb begin
      nxt_state = st;
      mode_nxt  = st.mode;
      ping_req  = 1'b0;
      idx_q     = 1'b0;
      just      = 1'b0;
      if (ping_due) begin
         ping_req                = 1'b1;
         idx_q                   = (st.mode == MODE_UNIDX);
         nxt_state.ping_stamp    = beat.now_time;
         nxt_state.ping_answered = 1'b0;
      end
      case (st.mode)
         MODE_OOS: begin
            if (beat.synch_ok) begin
               nxt_state.synced        = 1'b1;
               nxt_state.ping_answered = 1'b1;
               nxt_state.ping_stamp    = beat.now_time;
            end
            nxt_state.stop_pending = 1'b0;
            if (st.synced || beat.synch_ok) begin
               just     = 1'b1;
               mode_nxt = MODE_UNIDX;
            end
         end
         MODE_UNIDX: begin
            if (st.stop_pending) begin
               nxt_state.stop_pending = 1'b0;
            end else if (st.indexed) begin
               mode_nxt = MODE_IDLE;
            end else if (st.start_pending) begin
               nxt_state.start_pending = 1'b0;
               mode_nxt                = MODE_RUN;
            end
         end
         MODE_IDLE: begin
            if (st.start_pending) begin
               nxt_state.start_pending = 1'b0;
               mode_nxt                = MODE_RUN;
            end
         end
         MODE_RUN: begin
            if (!st.safe_level) begin
               mode_nxt = MODE_UNSAFE;
            end else if (st.stop_pending) begin
               nxt_state.stop_pending = 1'b0;
               mode_nxt               = MODE_BRAKE;
            end
         end
         MODE_UNSAFE: begin
            if (st.safe_level) begin
               mode_nxt = st.indexed ? MODE_IDLE : MODE_UNIDX;
            end
         end
         MODE_BRAKE: begin
            if (st.motor_is_off) begin
               mode_nxt = st.indexed ? MODE_IDLE : MODE_UNIDX;
            end
         end
         default: begin
            mode_nxt = st.mode;
         end
      endcase
      nxt_state.mode = mode_nxt;

      result.mode_code    = mode_nxt;
      result.pass_status  = status;
      result.ping_request = ping_req;
      result.index_query  = idx_q;
      result.just_synched = just;

      if (lost) begin
         nxt_state           = SUP_STATE_RESET;
         result.mode_code    = MODE_OOS;
         result.pass_status  = STATUS_LOST;
         result.ping_request = 1'b0;
         result.index_query  = 1'b0;
         result.just_synched = 1'b0;
      end
   end

endmodule
